// ===== rtl/cad_pkg.sv =====
// cad_pkg: shared types, constants and constant functions of the cobalt aqm
// drop decision block; used by cobalt_aqm_drop_decision
// depends on nothing
package cad_pkg;

  localparam int unsigned CACHE_DEPTH_DEF = 16;
  localparam logic [16:0] PROB_ONE = 17'd65536;

  // event kinds carried in the input tuser
  typedef enum logic [1:0] {
    OP_DEQUEUE  = 2'd0,
    OP_EMPTY    = 2'd1,
    OP_OVERFLOW = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_INTERVAL = 3'd0,
    REG_TARGET   = 3'd1,
    REG_USE_ECN  = 3'd2,
    REG_BLUE_INC = 3'd3,
    REG_BLUE_DEC = 3'd4,
    REG_BLUE_INI = 3'd5
  } reg_idx_t;

  // one newton step of the q0.32 inverse square root, elaboration use only
  function automatic logic [31:0] newton_step(input logic [31:0] v, input logic [31:0] c);
    logic [63:0] s;
    logic [63:0] w;
    s = ({32'b0, v} * {32'b0, v}) >> 32;
    w = (64'd3 << 32) - ({32'b0, c} * s);
    w = w >> 2;
    w = (w * {32'b0, v}) >> 31;
    return w[31:0];
  endfunction

  // small-count table entry: four newton steps per count from all ones
  function automatic logic [31:0] isqrt_entry(input int unsigned c);
    logic [31:0] v;
    v = '1;
    for (int unsigned k = 1; k <= c; k++) begin
      v = newton_step(v, 32'(k));
      v = newton_step(v, 32'(k));
      v = newton_step(v, 32'(k));
      v = newton_step(v, 32'(k));
    end
    return v;
  endfunction

endpackage

// ===== rtl/cad_mul.sv =====
// cad_mul: shared 32x32 unsigned multiplier with registered product
// depends on nothing
module cad_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod_r
);

  // product registered every cycle
  always_ff @(posedge clk) begin
    prod_r <= {32'b0, a} * {32'b0, b};
  end

endmodule

// ===== rtl/cobalt_aqm_drop_decision.sv =====
// cobalt_aqm_drop_decision: codel plus blue drop/mark decision engine
// depends on cad_pkg and cad_mul
//
// usage: one event request enters on in_* (tuser = event kind, tdata = now,
// sojourn, ecn capability and random draw); one result leaves on out_*
// (drop, mark, dropping flag, drop count, blue probability).
// the block takes one request at a time and is not ready while it works.
// each inverse square root refresh uses the table for counts below CACHE_DEPTH
// and otherwise a newton step (four passes through the one shared multiplier);
// the codel catch-up loop repeats that refresh once per count decrement.
// the result sits in an output register; a stalled receiver holds the block
// in its final state until the previous result is taken. config writes are taken only
// while the block is idle (cfg_ready follows in_tready).
// reset (rst_n low, synchronous) loads the register defaults, clears codel
// state and sets the inverse square root to all ones; no clearing pass.
module cobalt_aqm_drop_decision #(
  parameter int unsigned CACHE_DEPTH = cad_pkg::CACHE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // input requests
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_tuser,   // operation
  input  logic [111:0]  in_tdata,   // now_ns[61:0], sojourn_ns[93:62], ecn_capable[94],
                                    // random_u[110:95], zero pad
  // results
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [55:0]   out_tdata,  // drop[0], mark[1], in_dropping[2],
                                    // drop_count[34:3], blue_prob[51:35], zero pad
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int unsigned IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_EVAL   = 16'h0002,
    S_LAWNOW = 16'h0004,
    S_DECIDE = 16'h0008,
    S_REF    = 16'h0010,
    S_N2     = 16'h0020,
    S_N3     = 16'h0040,
    S_N4     = 16'h0080,
    S_N5     = 16'h0100,
    S_N6     = 16'h0200,
    S_LAW    = 16'h0400,
    S_LAW2   = 16'h0800,
    S_CHK    = 16'h1000,
    S_FIN    = 16'h2000,
    S_BLUE   = 16'h4000,
    S_POST   = 16'h8000
  } state_t;

  // small-count inverse square root table
  logic [31:0] isqrt_tab [CACHE_DEPTH];
  for (genvar g = 0; g < CACHE_DEPTH; g++) begin : g_tab
    localparam logic [31:0] ENTRY = cad_pkg::isqrt_entry(g);
    assign isqrt_tab[g] = ENTRY;
  end

  state_t      state_r, state_nxt;
  // config registers
  logic [31:0] interval_r, target_r;
  logic        use_ecn_r;
  logic [16:0] blue_inc_r, blue_dec_r;
  // codel and blue state
  logic        dropping_r;
  logic [31:0] count_r;
  logic [63:0] drop_next_r;
  logic [31:0] inv_r;
  logic [63:0] last_blue_r;
  logic [16:0] prob_r;
  // request latch and work registers
  logic [1:0]  op_r;
  logic [61:0] now_r;
  logic [31:0] soj_r;
  logic        ecn_r;
  logic [15:0] rnd_r;
  logic [63:0] sched_r, hold_r, lo_r;
  logic [61:0] w2_r;
  logic        due_r, drop_r, mark_r, loop_r;
  // output register
  logic        out_valid_r;
  logic [55:0] out_data_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] now64, diff_now, w_full, nsum;
  logic [17:0] prob_up;
  logic [16:0] ini_clamp;
  logic        blue_hit, out_free;

  cad_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  assign now64     = {2'b0, now_r};
  assign diff_now  = now64 - drop_next_r;
  assign w_full    = (64'd3 << 32) - prod;
  assign nsum      = lo_r + {prod[31:0], 32'b0};
  assign prob_up   = {1'b0, prob_r} + {1'b0, blue_inc_r};
  assign ini_clamp = (cfg_data[16:0] > cad_pkg::PROB_ONE) ? cad_pkg::PROB_ONE : cfg_data[16:0];
  assign blue_hit  = (prob_r != 17'd0) && ({1'b0, rnd_r} < prob_r);
  assign out_free  = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // multiplier operand selection
  always_comb begin
    mul_a = interval_r;
    mul_b = inv_r;
    unique case (state_r)
      S_REF: begin
        mul_a = inv_r;
        mul_b = inv_r;
      end
      S_N2: begin
        mul_a = count_r;
        mul_b = prod[63:32];
      end
      S_N4: begin
        mul_a = w2_r[31:0];
        mul_b = inv_r;
      end
      S_N5: begin
        mul_a = {2'b0, w2_r[61:32]};
        mul_b = inv_r;
      end
      default: begin
        mul_a = interval_r;
        mul_b = inv_r;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_EVAL;
      S_EVAL: begin
        priority case (op_r)
          cad_pkg::OP_DEQUEUE: begin
            if (soj_r > target_r && !dropping_r) state_nxt = S_LAWNOW;
            else state_nxt = S_DECIDE;
          end
          cad_pkg::OP_EMPTY, cad_pkg::OP_OVERFLOW: state_nxt = S_BLUE;
          default: state_nxt = S_POST;
        endcase
      end
      S_LAWNOW: state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = due_r ? S_REF : S_FIN;
      S_REF:    state_nxt = (count_r < 32'(CACHE_DEPTH)) ? S_LAW : S_N2;
      S_N2:     state_nxt = S_N3;
      S_N3:     state_nxt = S_N4;
      S_N4:     state_nxt = S_N5;
      S_N5:     state_nxt = S_N6;
      S_N6:     state_nxt = S_LAW;
      S_LAW:    state_nxt = S_LAW2;
      S_LAW2:   state_nxt = (op_r == cad_pkg::OP_DEQUEUE) ? S_CHK : S_POST;
      S_CHK: begin
        if (loop_r && count_r != 32'd0 && !diff_now[63]) state_nxt = S_REF;
        else state_nxt = S_FIN;
      end
      S_FIN:    state_nxt = S_POST;
      S_BLUE: begin
        if (op_r == cad_pkg::OP_EMPTY && count_r != 32'd0 && !sched_r[63]) state_nxt = S_REF;
        else state_nxt = S_POST;
      end
      S_POST:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      interval_r  <= 32'd100000000;
      target_r    <= 32'd5000000;
      use_ecn_r   <= 1'b0;
      blue_inc_r  <= 17'd256;
      blue_dec_r  <= 17'd16;
      dropping_r  <= 1'b0;
      count_r     <= 32'd0;
      drop_next_r <= 64'd0;
      inv_r       <= '1;
      last_blue_r <= 64'd0;
      prob_r      <= 17'd0;
      out_valid_r <= 1'b0;
      loop_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // output valid: set on a new result, cleared when taken
      if (state_r == S_POST && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        // latch the request
        S_IDLE: begin
          if (in_tvalid) begin
            op_r  <= in_tuser;
            now_r <= in_tdata[61:0];
            soj_r <= in_tdata[93:62];
            ecn_r <= in_tdata[94];
            rnd_r <= in_tdata[110:95];
          end
        end
        // schedule difference, blue hold-off, codel entry
        S_EVAL: begin
          sched_r <= diff_now;
          hold_r  <= now64 - last_blue_r - {32'b0, target_r};
          drop_r  <= 1'b0;
          mark_r  <= 1'b0;
          due_r   <= (count_r != 32'd0) && !diff_now[63];
          if (op_r == cad_pkg::OP_DEQUEUE) begin
            if (soj_r > target_r) begin
              dropping_r <= 1'b1;
              if (count_r == 32'd0) count_r <= 32'd1;
            end else begin
              dropping_r <= 1'b0;
            end
          end
        end
        // control law from now on entering the dropping state
        S_LAWNOW: drop_next_r <= now64 + {32'b0, prod[63:32]};
        // codel drop or catch-up decrement
        S_DECIDE: begin
          if (due_r && dropping_r) begin
            mark_r <= use_ecn_r && ecn_r;
            drop_r <= !(use_ecn_r && ecn_r);
            if (count_r != '1) count_r <= count_r + 32'd1;
            loop_r <= 1'b0;
          end else if (due_r) begin
            count_r <= count_r - 32'd1;
            loop_r  <= 1'b1;
          end
        end
        // table lookup for small counts
        S_REF: begin
          if (count_r < 32'(CACHE_DEPTH)) inv_r <= isqrt_tab[count_r[IDX_W-1:0]];
        end
        // newton step w = (3 - c*v*v) / 4
        S_N3: w2_r <= w_full[63:2];
        S_N5: lo_r <= prod;
        S_N6: inv_r <= nsum[62:31];
        // control law on the next drop time
        S_LAW2: drop_next_r <= drop_next_r + {32'b0, prod[63:32]};
        // recheck schedule after a step
        S_CHK: begin
          sched_r <= diff_now;
          if (loop_r && count_r != 32'd0 && !diff_now[63]) count_r <= count_r - 32'd1;
        end
        // blue drop and next drop time
        S_FIN: begin
          drop_r <= drop_r || blue_hit;
          mark_r <= mark_r && !(drop_r || blue_hit);
          if (count_r == 32'd0) begin
            drop_next_r <= now64 + {32'b0, interval_r};
          end else if (sched_r != 64'd0 && !sched_r[63] && !(drop_r || blue_hit)) begin
            drop_next_r <= now64;
          end
        end
        // blue probability update for empty and overflow events
        S_BLUE: begin
          if (op_r == cad_pkg::OP_EMPTY) begin
            if (prob_r != 17'd0 && hold_r != 64'd0 && !hold_r[63]) begin
              prob_r      <= (blue_dec_r >= prob_r) ? 17'd0 : prob_r - blue_dec_r;
              last_blue_r <= now64;
            end
            dropping_r <= 1'b0;
            if (count_r != 32'd0 && !sched_r[63]) count_r <= count_r - 32'd1;
          end else begin
            if (hold_r != 64'd0 && !hold_r[63]) begin
              prob_r      <= (prob_up > {1'b0, cad_pkg::PROB_ONE}) ? cad_pkg::PROB_ONE
                                                                    : prob_up[16:0];
              last_blue_r <= now64;
            end
            dropping_r  <= 1'b1;
            drop_next_r <= now64;
            if (count_r == 32'd0) count_r <= 32'd1;
          end
        end
        // result into the output register
        S_POST: begin
          if (out_free) begin
            out_data_r  <= {4'b0, prob_r, count_r, dropping_r, mark_r, drop_r};
          end
        end
        default: ;
      endcase
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          cad_pkg::REG_INTERVAL: interval_r <= cfg_data;
          cad_pkg::REG_TARGET:   target_r   <= cfg_data;
          cad_pkg::REG_USE_ECN:  use_ecn_r  <= cfg_data[0];
          cad_pkg::REG_BLUE_INC: blue_inc_r <= cfg_data[16:0];
          cad_pkg::REG_BLUE_DEC: blue_dec_r <= cfg_data[16:0];
          cad_pkg::REG_BLUE_INI: prob_r     <= ini_clamp;
          default: ;
        endcase
      end
    end
  end

endmodule
